FILE: src/cmt_pkg.sv
// ----------------------------------------------------------------------------
// cmt_pkg
// Shared types and constants of the counting multiset table: field widths,
// operation codes and the command word from controller to datapath.
// ----------------------------------------------------------------------------
package cmt_pkg;

  localparam int MODE_W     = 2;
  localparam int VALUE_W    = 32;
  localparam int OCC_W      = 16;
  localparam int TOTAL_W    = 20;
  localparam int DISTINCT_W = 5;

  typedef logic        [MODE_W-1:0]     mode_t;
  typedef logic signed [VALUE_W-1:0]    value_t;
  typedef logic        [OCC_W-1:0]      occ_t;
  typedef logic        [TOTAL_W-1:0]    total_t;
  typedef logic        [DISTINCT_W-1:0] distinct_t;

  // operation codes; the remaining codes only report
  localparam mode_t MODE_ADD    = 2'd0;
  localparam mode_t MODE_REMOVE = 2'd1;

  typedef struct packed {
    logic clr_wr;  // clear the count of one entry (power-up sweep)
    logic load;    // capture a new item, restart the scan flags
    logic rd_en;   // read one entry of the table
    logic upd;     // apply the operation and load the result register
  } cmd_t;

endpackage

FILE: src/cmt_ifs.sv
// ----------------------------------------------------------------------------
// cmt_ifs
// Valid/ready channels of the counting multiset table: operation input and
// result output.
// ----------------------------------------------------------------------------
interface cmt_in_if;
  logic            valid;
  logic            ready;
  cmt_pkg::mode_t  mode;
  cmt_pkg::value_t value;

  modport source (output valid, output mode, output value, input ready);
  modport sink   (input valid, input mode, input value, output ready);
endinterface

interface cmt_out_if;
  logic               valid;
  logic               ready;
  logic               found;
  cmt_pkg::occ_t      occurrences;
  cmt_pkg::total_t    total_size;
  cmt_pkg::distinct_t distinct_values;
  logic               is_empty;
  logic               rejected;

  modport source (output valid, output found, output occurrences, output total_size,
                  output distinct_values, output is_empty, output rejected,
                  input ready);
  modport sink   (input valid, input found, input occurrences, input total_size,
                  input distinct_values, input is_empty, input rejected,
                  output ready);
endinterface

FILE: src/counting_multiset_table_top.sv
// ----------------------------------------------------------------------------
// counting_multiset_table_top
// Bag of 32-bit values with per-value counts, kept in a table of value and
// count pairs; add, remove and query with bag totals in every result.
// ----------------------------------------------------------------------------
// After reset the block sweeps the count memory to zero, one entry per cycle,
// and holds in_i.ready low meanwhile. Each item then passes through a scan,
// a drain and an update state from transfer to result: the table has a single
// read port and is scanned one entry per cycle, followed by a drain state for
// the last read and an update state that writes the entry and loads the result
// register. A new item is taken in that update state once the result register
// is not held by the output, so no item enters before the last one is through.
// A value takes the lowest-numbered free entry; counts saturate at
// 2^COUNT_BITS-1 and an add of a new value to a full table comes back with
// rejected set and leaves the table unchanged.
module counting_multiset_table_top #(
  parameter int TABLE_DEPTH = 16,
  parameter int COUNT_BITS  = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  cmt_in_if.sink     in_i,
  cmt_out_if.source  out_o
);
  import cmt_pkg::*;

  localparam int AddrW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  cmd_t             cmd;
  logic [AddrW-1:0] addr;
  logic             out_busy;

  cmt_ctrl #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .ADDR_W      (AddrW)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .out_busy_i (out_busy),
    .cmd_o      (cmd),
    .addr_o     (addr)
  );

  cmt_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .COUNT_BITS  (COUNT_BITS),
    .ADDR_W      (AddrW)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .addr_i     (addr),
    .mode_i     (in_i.mode),
    .value_i    (in_i.value),
    .out_busy_o (out_busy),
    .out_o      (out_o)
  );

  // a transfer starts a scan, so the input closes for the next cycle
  a_busy_after_transfer : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("input ready right after a transfer");

  // a new result only ever comes from an update cycle
  a_result_from_update : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_o.valid) |-> $past(cmd.upd))
    else $error("result valid without update");

  a_reject_clean : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.rejected) |-> (!out_o.found && out_o.occurrences == '0))
    else $error("rejected add reports a count");

  a_empty_total : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.is_empty) |-> (out_o.total_size == '0))
    else $error("empty bag with nonzero total");

endmodule

FILE: src/cmt_ctrl.sv
// ----------------------------------------------------------------------------
// cmt_ctrl
// Sequencer of the table: power-up clear sweep, one read per entry during
// the scan, a drain state for the last read, then the update state.
// ----------------------------------------------------------------------------
module cmt_ctrl #(
  parameter int TABLE_DEPTH = 16,
  parameter int ADDR_W      = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              out_busy_i,
  output cmt_pkg::cmd_t     cmd_o,
  output logic [ADDR_W-1:0] addr_o
);
  import cmt_pkg::*;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_UPDATE
  } state_e;

  localparam logic [ADDR_W-1:0] LastAddr = ADDR_W'(TABLE_DEPTH - 1);

  state_e            state_q;
  logic [ADDR_W-1:0] cnt_q;
  logic              accept;

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_CLEAR:  cmd_o.clr_wr = 1'b1;
      ST_IDLE:   in_ready_o = 1'b1;
      ST_SCAN:   cmd_o.rd_en = 1'b1;
      ST_DRAIN:  ;
      ST_UPDATE: begin
        // next item may enter as soon as this result is placed
        cmd_o.upd  = ~out_busy_i;
        in_ready_o = ~out_busy_i;
      end
      default: ;
    endcase
    accept     = in_valid_i & in_ready_o;
    cmd_o.load = accept;
  end

  assign addr_o = cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      cnt_q   <= '0;
    end else begin
      case (state_q)
        ST_CLEAR: begin
          if (cnt_q == LastAddr) begin
            state_q <= ST_IDLE;
            cnt_q   <= '0;
          end else begin
            cnt_q <= cnt_q + ADDR_W'(1);
          end
        end
        ST_IDLE: begin
          if (accept) begin
            state_q <= ST_SCAN;
            cnt_q   <= '0;
          end
        end
        ST_SCAN: begin
          if (cnt_q == LastAddr) begin
            state_q <= ST_DRAIN;
          end else begin
            cnt_q <= cnt_q + ADDR_W'(1);
          end
        end
        ST_DRAIN: state_q <= ST_UPDATE;
        ST_UPDATE: begin
          if (!out_busy_i) begin
            cnt_q <= '0;
            if (accept) begin
              state_q <= ST_SCAN;
            end else begin
              state_q <= ST_IDLE;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

FILE: src/cmt_datapath.sv
// ----------------------------------------------------------------------------
// cmt_datapath
// Entry table (value and count memories), scan match logic, bag totals and
// the result register.
// ----------------------------------------------------------------------------
module cmt_datapath #(
  parameter int TABLE_DEPTH = 16,
  parameter int COUNT_BITS  = 16,
  parameter int ADDR_W      = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cmt_pkg::cmd_t     cmd_i,
  input  logic [ADDR_W-1:0] addr_i,
  input  cmt_pkg::mode_t    mode_i,
  input  cmt_pkg::value_t   value_i,
  output logic              out_busy_o,
  cmt_out_if.source         out_o
);
  import cmt_pkg::*;

  localparam int OccupW  = $clog2(TABLE_DEPTH + 1);
  localparam int SumW    = COUNT_BITS + OccupW;
  localparam int OccXW   = (COUNT_BITS > OCC_W) ? COUNT_BITS : OCC_W;
  localparam int TotXW   = (SumW > TOTAL_W) ? SumW : TOTAL_W;
  localparam int DistXW  = (OccupW > DISTINCT_W) ? OccupW : DISTINCT_W;
  localparam logic [COUNT_BITS-1:0] CountMax = '1;

  // table storage; value entries are only trusted while their count is nonzero
  logic [VALUE_W-1:0]    val_mem [TABLE_DEPTH];
  logic [COUNT_BITS-1:0] cnt_mem [TABLE_DEPTH];

  mode_t                 item_mode_q;
  value_t                item_value_q;
  logic [VALUE_W-1:0]    rd_val_q;
  logic [COUNT_BITS-1:0] rd_cnt_q;
  logic [ADDR_W-1:0]     rd_addr_q;
  logic                  rd_vld_q;
  logic                  hit_q, free_q;
  logic [ADDR_W-1:0]     hit_idx_q, free_idx_q;
  logic [COUNT_BITS-1:0] hit_cnt_q;
  logic [SumW-1:0]       sum_q, sum_d;
  logic [OccupW-1:0]     occup_q, occup_d;
  logic                  rd_hit, rd_free;

  logic                  cnt_we, val_we;
  logic [ADDR_W-1:0]     cnt_wa;
  logic [COUNT_BITS-1:0] cnt_wd, occ;
  logic                  rej;

  assign rd_hit  = rd_vld_q & (rd_cnt_q != '0) & (rd_val_q == item_value_q);
  assign rd_free = rd_vld_q & (rd_cnt_q == '0);

  always_comb begin
    cnt_we  = 1'b0;
    cnt_wa  = hit_idx_q;
    cnt_wd  = hit_cnt_q;
    val_we  = 1'b0;
    sum_d   = sum_q;
    occup_d = occup_q;
    occ     = '0;
    rej     = 1'b0;
    if (cmd_i.clr_wr) begin
      cnt_we = 1'b1;
      cnt_wa = addr_i;
      cnt_wd = '0;
    end else if (cmd_i.upd) begin
      case (item_mode_q)
        MODE_ADD: begin
          if (hit_q) begin
            occ = hit_cnt_q;
            // count saturates, totals stay put
            if (hit_cnt_q != CountMax) begin
              cnt_we = 1'b1;
              cnt_wd = hit_cnt_q + COUNT_BITS'(1);
              occ    = hit_cnt_q + COUNT_BITS'(1);
              sum_d  = sum_q + SumW'(1);
            end
          end else if (free_q) begin
            cnt_we  = 1'b1;
            cnt_wa  = free_idx_q;
            cnt_wd  = COUNT_BITS'(1);
            val_we  = 1'b1;
            sum_d   = sum_q + SumW'(1);
            occup_d = occup_q + OccupW'(1);
            occ     = COUNT_BITS'(1);
          end else begin
            rej = 1'b1;
          end
        end
        MODE_REMOVE: begin
          if (hit_q) begin
            cnt_we = 1'b1;
            cnt_wd = hit_cnt_q - COUNT_BITS'(1);
            occ    = hit_cnt_q - COUNT_BITS'(1);
            sum_d  = sum_q - SumW'(1);
            if (hit_cnt_q == COUNT_BITS'(1)) begin
              occup_d = occup_q - OccupW'(1);
            end
          end
        end
        default: begin
          if (hit_q) begin
            occ = hit_cnt_q;
          end
        end
      endcase
    end
  end

  // memories: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (cnt_we) begin
      cnt_mem[cnt_wa] <= cnt_wd;
    end
    if (val_we) begin
      val_mem[free_idx_q] <= item_value_q;
    end
    if (cmd_i.rd_en) begin
      rd_val_q  <= val_mem[addr_i];
      rd_cnt_q  <= cnt_mem[addr_i];
      rd_addr_q <= addr_i;
    end
  end

  // item capture and scan results
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_mode_q  <= mode_i;
      item_value_q <= value_i;
    end
    if (rd_hit && !hit_q) begin
      hit_idx_q <= rd_addr_q;
      hit_cnt_q <= rd_cnt_q;
    end
    if (rd_free && !free_q) begin
      free_idx_q <= rd_addr_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
      hit_q    <= 1'b0;
      free_q   <= 1'b0;
      sum_q    <= '0;
      occup_q  <= '0;
    end else begin
      rd_vld_q <= cmd_i.rd_en;
      sum_q    <= sum_d;
      occup_q  <= occup_d;
      if (cmd_i.load) begin
        hit_q  <= 1'b0;
        free_q <= 1'b0;
      end else begin
        if (rd_hit) begin
          hit_q <= 1'b1;
        end
        if (rd_free) begin
          free_q <= 1'b1;
        end
      end
    end
  end

  // result register
  logic [OccXW-1:0]  occ_x;
  logic [TotXW-1:0]  tot_x;
  logic [DistXW-1:0] dist_x;

  assign occ_x  = OccXW'(occ);
  assign tot_x  = TotXW'(sum_d);
  assign dist_x = DistXW'(occup_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_o.valid <= 1'b0;
    end else if (cmd_i.upd) begin
      out_o.valid <= 1'b1;
    end else if (out_o.ready) begin
      out_o.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.upd) begin
      out_o.found           <= hit_q;
      out_o.occurrences     <= occ_x[OCC_W-1:0];
      out_o.total_size      <= tot_x[TOTAL_W-1:0];
      out_o.distinct_values <= dist_x[DISTINCT_W-1:0];
      out_o.is_empty        <= (occup_d == '0);
      out_o.rejected        <= rej;
    end
  end

  assign out_busy_o = out_o.valid & ~out_o.ready;

endmodule
